FILE: rtl/saturating_mul_div_top_defines.svh
// Assertion macros used by the port-level checker of the saturating multiply-divide block.
`ifndef SATURATING_MUL_DIV_TOP_DEFINES_SVH
`define SATURATING_MUL_DIV_TOP_DEFINES_SVH

// Same-cycle implication, skipped while reset is asserted
`define SMD_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, skipped while reset is asserted
`define SMD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Condition that must hold in the cycle after reset is asserted
`define SMD_ASSERT_RESET(lbl, clk, rst_n, cons, msg) \
    lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) else $error(msg);

`endif

FILE: rtl/smd_pkg.sv
// Types and constants of the saturating multiply-divide block.
`timescale 1ns / 1ps

package smd_pkg;

    // Operand and result width
    localparam int DATA_W = 16;
    localparam int PROD_W = 2 * DATA_W;
    // Quotient bits produced by the divider; a larger quotient saturates
    localparam int Q_W    = DATA_W + 1;

    localparam int MODE_W = 2;
    localparam logic [MODE_W-1:0] MODE_SIGNED   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UNSIGNED = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ROUND    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;

    // Saturation magnitudes
    localparam logic [DATA_W-1:0] UNS_MAX = 16'hFFFF;
    localparam logic [DATA_W-1:0] POS_MAX = 16'h7FFF;
    localparam logic [DATA_W-1:0] NEG_MAG = 16'h8000;

    // Divider layout: quotient bits resolved per stage, and stage counts
    localparam int DIV_BPS    = 4;
    localparam int DIV_STAGES = (Q_W + DIV_BPS - 1) / DIV_BPS;
    localparam int PRE_STAGES = 4;
    localparam int NUM_STAGES = PRE_STAGES + DIV_STAGES;

    // Everything one item carries down the pipeline
    typedef struct packed {
        logic              neg;
        logic              rnd;
        logic [DATA_W-1:0] lim;
        logic [DATA_W-1:0] ma;
        logic [DATA_W-1:0] mb;
        logic [DATA_W-1:0] mc;
        logic [PROD_W-1:0] prod;
        logic              ovf;
        logic              fzero;
        logic [DATA_W-1:0] rem;
        logic [Q_W-1:0]    dvd;
        logic [Q_W-1:0]    q;
    } t_smd_stage;

endpackage

FILE: rtl/saturating_mul_div_top.sv
// Channel | Dir | Handshake         | Fields
// in      | in  | i_valid / o_stall | i_mode, i_mult_a, i_mult_b, i_divisor
// out     | out | o_valid / i_stall | o_quotient
//
// One item per cycle while the output is not stalled. The pipeline ends in a
// restoring divider (17 quotient bits, 4 per stage) that sits behind stages for
// operand magnitude, multiply, rounding add and range check.
// Reset clears the valid bits only.
// A stall holds the output; each earlier stage still fills while it is empty.
`timescale 1ns / 1ps

module saturating_mul_div_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [smd_pkg::MODE_W-1:0]   i_mode,
    input  logic [smd_pkg::DATA_W-1:0]   i_mult_a,
    input  logic [smd_pkg::DATA_W-1:0]   i_mult_b,
    input  logic [smd_pkg::DATA_W-1:0]   i_divisor,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [smd_pkg::DATA_W-1:0]   o_quotient
);
    import smd_pkg::*;

    localparam int NS = NUM_STAGES;

    t_smd_stage        r_d [NS];
    t_smd_stage        n_d [NS];
    logic [NS-1:0]     r_v;
    logic [NS-1:0]     n_v;
    logic [NS:0]       en;
    logic              r_ov;
    logic [DATA_W-1:0] r_quot;
    logic [DATA_W-1:0] n_quot;

    // Advance a stage when it is empty or the stage after it advances
    always_comb begin
        en[NS] = !r_ov || !i_stall;
        for (int k = NS - 1; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_stall = !en[0];
    assign n_v     = {r_v[NS-2:0], i_valid};

    // Stage 0: operand magnitudes, result sign and saturation limit
    always_comb begin
        logic v_sgn;
        v_sgn            = (i_mode == MODE_SIGNED);
        n_d[0]           = '0;
        n_d[0].neg       = v_sgn && (i_mult_a[DATA_W-1] ^ i_mult_b[DATA_W-1]
                                     ^ i_divisor[DATA_W-1]);
        n_d[0].rnd       = (i_mode == MODE_ROUND) || (i_mode == MODE_RESERVED);
        n_d[0].lim       = !v_sgn ? UNS_MAX : (n_d[0].neg ? NEG_MAG : POS_MAX);
        n_d[0].ma        = (v_sgn && i_mult_a[DATA_W-1]) ? (~i_mult_a + 1'b1) : i_mult_a;
        n_d[0].mb        = (v_sgn && i_mult_b[DATA_W-1]) ? (~i_mult_b + 1'b1) : i_mult_b;
        n_d[0].mc        = (v_sgn && i_divisor[DATA_W-1]) ? (~i_divisor + 1'b1) : i_divisor;
    end

    // Stage 1: magnitude product
    always_comb begin
        n_d[1]      = r_d[0];
        n_d[1].prod = PROD_W'(r_d[0].ma) * PROD_W'(r_d[0].mb);
    end

    // Stage 2: add half the divisor in round and reserved modes
    always_comb begin
        n_d[2]      = r_d[1];
        n_d[2].prod = r_d[1].prod + (r_d[1].rnd ? PROD_W'(r_d[1].mc >> 1) : '0);
    end

    // Stage 3: flag zero divisor and quotient overflow, load the divider
    always_comb begin
        logic v_czero;
        v_czero      = (r_d[2].mc == '0);
        n_d[3]       = r_d[2];
        n_d[3].fzero = v_czero && (r_d[2].prod == '0);
        n_d[3].ovf   = v_czero ? (r_d[2].prod != '0)
                               : (DATA_W'(r_d[2].prod[PROD_W-1:Q_W]) >= r_d[2].mc);
        n_d[3].rem   = DATA_W'(r_d[2].prod[PROD_W-1:Q_W]);
        n_d[3].dvd   = r_d[2].prod[Q_W-1:0];
        n_d[3].q     = '0;
    end

    // Divider stages: restoring steps, DIV_BPS quotient bits each
    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        always_comb begin
            logic [DATA_W:0] v_t;
            t_smd_stage      v_s;
            v_t = '0;
            v_s = r_d[PRE_STAGES+g-1];
            for (int j = 0; j < DIV_BPS; j++) begin
                if (g * DIV_BPS + j < Q_W) begin
                    v_t   = {v_s.rem, v_s.dvd[Q_W-1]};
                    v_s.dvd = {v_s.dvd[Q_W-2:0], 1'b0};
                    if (v_t >= {1'b0, v_s.mc}) begin
                        v_s.rem = DATA_W'(v_t - {1'b0, v_s.mc});
                        v_s.q   = {v_s.q[Q_W-2:0], 1'b1};
                    end else begin
                        v_s.rem = v_t[DATA_W-1:0];
                        v_s.q   = {v_s.q[Q_W-2:0], 1'b0};
                    end
                end
            end
            n_d[PRE_STAGES+g] = v_s;
        end
    end

    // Output stage: zero for a zero product over a zero divisor, else clip to the limit; restore the sign
    always_comb begin
        logic [DATA_W-1:0] v_mag;
        if (r_d[NS-1].fzero) begin
            v_mag = '0;
        end else if (r_d[NS-1].ovf || (r_d[NS-1].q > {1'b0, r_d[NS-1].lim})) begin
            v_mag = r_d[NS-1].lim;
        end else begin
            v_mag = r_d[NS-1].q[DATA_W-1:0];
        end
        n_quot = r_d[NS-1].neg ? (~v_mag + 1'b1) : v_mag;
    end

    // Pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (en[k]) begin
                    r_v[k] <= n_v[k];
                end
            end
            if (en[NS]) begin
                r_ov <= r_v[NS-1];
            end
        end
    end

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NS; k++) begin
            if (en[k]) begin
                r_d[k] <= n_d[k];
            end
        end
        if (en[NS]) begin
            r_quot <= n_quot;
        end
    end

    assign o_valid    = r_ov;
    assign o_quotient = r_quot;

endmodule

FILE: rtl/smd_checker.sv
// Port-level checker of the saturating multiply-divide block, bound to the top level.
`timescale 1ns / 1ps
`include "saturating_mul_div_top_defines.svh"

module smd_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic                         o_stall,
    input  logic [smd_pkg::MODE_W-1:0]   i_mode,
    input  logic [smd_pkg::DATA_W-1:0]   i_mult_a,
    input  logic [smd_pkg::DATA_W-1:0]   i_mult_b,
    input  logic [smd_pkg::DATA_W-1:0]   i_divisor,
    input  logic                         o_valid,
    input  logic                         i_stall,
    input  logic [smd_pkg::DATA_W-1:0]   o_quotient
);
    // Hold a stalled result item
    `SMD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        o_valid && i_stall, o_valid && $stable(o_quotient),
        "stalled result item changed")

    // Push back only when the output is full and stalled
    `SMD_ASSERT_IMPLIES(a_stall_src, i_clk, i_rst_n,
        o_stall, o_valid && i_stall,
        "input stalled while output drains")

    // Take items freely while the output drains
    `SMD_ASSERT_IMPLIES(a_free_flow, i_clk, i_rst_n,
        !i_stall, !o_stall,
        "input stalled with no output stall")

    // Drop all items on reset
    `SMD_ASSERT_RESET(a_reset_empty, i_clk, i_rst_n,
        !o_valid,
        "result item valid after reset")

endmodule

bind saturating_mul_div_top smd_checker u_smd_checker (.*);
